// ----- hw/rtl/s1w_pkg.sv -----
// Shared types and constants for the serial to one-wire bridge protocol unit.
package s1w_pkg;

    // Host byte codes
    localparam logic [7:0] CMD_DATA_MODE = 8'hE1;  // enter data mode
    localparam logic [7:0] CHECK_BYTE    = 8'hE3;  // escape to check mode
    localparam logic [7:0] CMD_IGNORE    = 8'hF1;  // no-op in command mode
    localparam logic [7:0] FUNC_MASK     = 8'h81;
    localparam logic [7:0] FUNC_COMMAND  = 8'h81;
    localparam logic [7:0] FUNC_CONFIG   = 8'h01;

    // Command function select (bits 6:5)
    localparam logic [1:0] FN_BIT     = 2'b00;
    localparam logic [1:0] FN_SEARCH  = 2'b01;
    localparam logic [1:0] FN_RESET   = 2'b10;
    localparam logic [1:0] FN_PULSE   = 2'b11;

    // Response bases
    localparam logic [7:0] RESP_BIT    = 8'h80;
    localparam logic [7:0] RESP_BIT_1  = 8'hEF;
    localparam logic [7:0] RESP_BIT_0  = 8'hEC;
    localparam logic [7:0] RESP_RESET  = 8'hCC;
    localparam logic [7:0] RESP_PULSE  = 8'hE0;

    // Reset status codes
    localparam logic [1:0] RST_SHORT    = 2'd0;
    localparam logic [1:0] RST_PRESENCE = 2'd1;
    localparam logic [1:0] RST_CODE_NONE = 2'd3;

    // Bus operation codes
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_BYTE   = 3'd1;
    localparam logic [2:0] OP_BIT    = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    localparam int         SEARCH_BYTES = 16;
    localparam logic [3:0] SEARCH_LAST  = 4'd15;

    typedef enum logic [1:0] {
        MODE_CMD   = 2'd0,
        MODE_TOUCH = 2'd1,
        MODE_CHECK = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0]  host_byte;
        logic [7:0]  bus_read_byte;
        logic        bus_read_bit;
        logic [1:0]  bus_reset_status;
        logic [63:0] search_id_bits;
        logic [63:0] search_cmp_bits;
        logic        chunk_end;
    } in_t;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       last_of_run;
        logic [2:0] bus_op;
        logic [7:0] bus_write_byte;
    } out_t;

    // Protocol state kept between host bytes
    typedef struct packed {
        mode_t           mode;
        logic [7:0]      check_byte;
        logic            search_en;
        logic [3:0]      search_cnt;
        logic [6:0][2:0] params;
    } st_t;

    // Search buffer write request
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    // Decoded run of response bytes for one host byte
    typedef struct packed {
        logic [15:0][7:0] bytes;
        logic [3:0]       last_idx;
        logic [2:0]       op;
        logic [7:0]       wr;
    } run_t;

endpackage

// ----- hw/rtl/s1w_decode.sv -----
// Combinational decode of one host byte into next state and a response run.
module s1w_decode (
    input  s1w_pkg::in_t             item,
    input  s1w_pkg::st_t             st,
    input  logic [15:0][7:0]         search_buf,
    output s1w_pkg::st_t             st_next,
    output s1w_pkg::buf_wr_t         buf_wr,
    output s1w_pkg::run_t            run,
    output logic                     run_has
);
    import s1w_pkg::*;

    always_comb begin
        logic [7:0]       b;
        logic             rb;
        logic [1:0]       code;
        logic [2:0]       wsel;
        logic [2:0]       rsel;
        logic [2:0]       pv;
        logic             id_b;
        logic             cmp_b;
        logic             path_b;
        logic             disc_b;
        logic [15:0][7:0] buf_eff;
        logic             cmd_run;

        b       = item.host_byte;
        rb      = item.bus_read_bit;
        st_next = st;
        buf_wr  = '0;
        run     = '0;
        run_has = 1'b0;
        cmd_run = 1'b0;
        code    = RST_SHORT;
        wsel    = b[6:4];
        rsel    = b[3:1];
        pv      = '0;
        id_b    = 1'b0;
        cmp_b   = 1'b0;
        path_b  = 1'b0;
        disc_b  = 1'b0;
        buf_eff = search_buf;
        buf_eff[SEARCH_LAST] = b;

        // Mode dispatch
        case (st.mode)
            MODE_TOUCH: begin
                if (b == CHECK_BYTE) begin
                    st_next.check_byte = CHECK_BYTE;
                    st_next.mode       = MODE_CHECK;
                end else if (st.search_en) begin
                    buf_wr.en   = 1'b1;
                    buf_wr.addr = st.search_cnt;
                    buf_wr.data = b;
                    if (st.search_cnt == SEARCH_LAST) begin
                        st_next.search_cnt = '0;
                        run_has            = 1'b1;
                        run.last_idx       = SEARCH_LAST;
                        run.op             = OP_SEARCH;
                        // Each position: both high -> path 1; differ -> path id;
                        // both low -> discrepancy, path from the host buffer
                        for (int j = 0; j < SEARCH_BYTES; j++) begin
                            for (int k = 0; k < 4; k++) begin
                                id_b  = item.search_id_bits[4*j+k];
                                cmp_b = item.search_cmp_bits[4*j+k];
                                if (id_b && cmp_b) begin
                                    path_b = 1'b1;
                                    disc_b = 1'b0;
                                end else if (id_b != cmp_b) begin
                                    path_b = id_b;
                                    disc_b = 1'b0;
                                end else begin
                                    path_b = buf_eff[j][2*k+1];
                                    disc_b = 1'b1;
                                end
                                run.bytes[j][2*k]   = disc_b;
                                run.bytes[j][2*k+1] = path_b;
                            end
                        end
                    end else begin
                        st_next.search_cnt = st.search_cnt + 4'd1;
                    end
                end else begin
                    run_has      = 1'b1;
                    run.bytes[0] = item.bus_read_byte;
                    run.op       = OP_BYTE;
                    run.wr       = b;
                end
            end
            MODE_CHECK: begin
                if (b == st.check_byte) begin
                    run_has      = 1'b1;
                    run.bytes[0] = item.bus_read_byte;
                    run.op       = OP_BYTE;
                    run.wr       = b;
                    st_next.mode = MODE_TOUCH;
                end else begin
                    cmd_run = 1'b1;
                end
            end
            default: begin
                cmd_run = 1'b1;
            end
        endcase

        // Command decode
        if (cmd_run) begin
            if (b == CMD_DATA_MODE) begin
                st_next.mode = MODE_TOUCH;
            end else if (b == CMD_IGNORE || b == CHECK_BYTE) begin
                run_has = 1'b0;
            end else if ((b & FUNC_MASK) == FUNC_COMMAND) begin
                case (b[6:5])
                    FN_BIT: begin
                        run_has      = 1'b1;
                        run.op       = OP_BIT;
                        run.wr       = {7'd0, b[4]};
                        run.bytes[0] = RESP_BIT | {3'd0, b[4], 4'd0}
                                     | {4'd0, b[3:2], 2'd0} | {6'd0, rb, rb};
                        if (b[1]) begin
                            run.bytes[1] = rb ? RESP_BIT_1 : RESP_BIT_0;
                            run.last_idx = 4'd1;
                        end
                    end
                    FN_SEARCH: begin
                        st_next.search_en  = b[4];
                        st_next.search_cnt = '0;
                    end
                    FN_RESET: begin
                        if (item.bus_reset_status == RST_PRESENCE) begin
                            code = RST_PRESENCE;
                        end else if (item.bus_reset_status == RST_SHORT) begin
                            code = RST_SHORT;
                        end else begin
                            code = RST_CODE_NONE;
                        end
                        run_has      = 1'b1;
                        run.op       = OP_RESET;
                        run.bytes[0] = RESP_RESET | {6'd0, code};
                    end
                    default: begin
                        run_has      = 1'b1;
                        run.bytes[0] = RESP_PULSE | {3'd0, b[4], 2'd0, b[1], 1'b0};
                    end
                endcase
            end else if ((b & FUNC_MASK) == FUNC_CONFIG) begin
                run_has = 1'b1;
                if (wsel != 3'd0) begin
                    st_next.params[wsel - 3'd1] = b[3:1];
                    run.bytes[0] = {1'b0, wsel, b[3:1], 1'b0};
                end else begin
                    if (rsel != 3'd0) begin
                        pv = st.params[rsel - 3'd1];
                    end
                    run.bytes[0] = {4'd0, pv, 1'b0};
                end
            end
            // A command that arrives in check mode always drops back to command mode
            if (st.mode == MODE_CHECK) begin
                st_next.mode = MODE_CMD;
            end
        end
    end

endmodule

// ----- hw/rtl/serial_to_onewire_bridge_protocol_unit.sv -----
// Top level of the serial to one-wire bridge protocol unit.
//
// Host bytes enter on the s_ channel (valid/ready), each together with the
// bus answers that belong to it. Responses leave on the m_ channel, one
// byte per transfer; last_of_run marks the final response of a host byte,
// and bus_op / bus_write_byte are set on the first response only.
// A host byte may cause no response, one, two, or sixteen (search run).
// A byte taken sits in the input register, is decoded into the result
// register once that register is free, and its first response is offered
// from then on. Throughput is one host byte per cycle while each byte
// causes at most one response and m_ready stays high; a longer run holds
// the result register until its last response is taken, during which one
// more byte waits in the input register and s_ready drops.
// When the receiver stalls (m_ready low) the result register holds and the
// input register fills, then s_ready goes low; nothing is dropped.
// Reset (aresetn low, synchronous) empties both registers and returns the
// protocol to command mode with the search accelerator off, the search
// count at zero and all parameter codes zero.
module serial_to_onewire_bridge_protocol_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  s1w_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output s1w_pkg::out_t m_data
);
    import s1w_pkg::*;

    logic             in_valid_reg, in_valid_next;
    in_t              in_data_reg;
    st_t              st_reg;
    logic [15:0][7:0] search_buf_reg;
    logic             run_valid_reg, run_valid_next;
    logic [3:0]       run_idx_reg, run_idx_next;
    run_t             run_reg;

    st_t              st_next;
    buf_wr_t          buf_wr;
    run_t             dec_run;
    logic             dec_has;
    logic             run_last;
    logic             run_free;
    logic             dec_go;

    s1w_decode u_decode (
        .item       (in_data_reg),
        .st         (st_reg),
        .search_buf (search_buf_reg),
        .st_next    (st_next),
        .buf_wr     (buf_wr),
        .run        (dec_run),
        .run_has    (dec_has)
    );

    // Handshake control
    assign run_last = (run_idx_reg == run_reg.last_idx);
    assign run_free = !run_valid_reg || (m_ready && run_last);
    assign dec_go   = in_valid_reg && run_free;
    assign s_ready  = !in_valid_reg || run_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (dec_go) begin
            in_valid_next = 1'b0;
        end
        if (dec_go) begin
            run_valid_next = dec_has;
            run_idx_next   = '0;
        end else if (run_valid_reg && m_ready) begin
            // last response gone with nothing behind it: result side empties
            if (run_last) begin
                run_valid_next = 1'b0;
                run_idx_next   = '0;
            end else begin
                run_idx_next = run_idx_reg + 4'd1;
            end
        end
    end

    // Control registers and protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            st_reg.mode       <= MODE_CMD;
            st_reg.check_byte <= CHECK_BYTE;
            st_reg.search_en  <= 1'b0;
            st_reg.search_cnt <= '0;
            st_reg.params     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            if (dec_go) begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (dec_go) begin
            run_reg <= dec_run;
        end
        if (dec_go && buf_wr.en) begin
            search_buf_reg[buf_wr.addr] <= buf_wr.data;
        end
    end

    // Result channel
    assign m_valid               = run_valid_reg;
    assign m_data.response_byte  = run_reg.bytes[run_idx_reg];
    assign m_data.last_of_run    = run_last;
    assign m_data.bus_op         = (run_idx_reg == 4'd0) ? run_reg.op : OP_NONE;
    assign m_data.bus_write_byte = (run_idx_reg == 4'd0) ? run_reg.wr : 8'd0;

endmodule

// ----- bench/serial_to_onewire_bridge_protocol_unit_test.sv -----
// Self-checking bench for the serial to one-wire bridge protocol unit.
module serial_to_onewire_bridge_protocol_unit_test;
    import s1w_pkg::*;

    localparam int RANDOM_ITEMS   = 440;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PERCENT   = 29;
    localparam int QUIET_FIRST    = 200;
    localparam int QUIET_LAST     = 320;
    localparam int REPORT_LIMIT   = 10;

    // Search control bytes: accelerator on / off (bit 4), function 01
    localparam logic [7:0] SEARCH_ON_CMD  = 8'hB1;
    localparam logic [7:0] SEARCH_OFF_CMD = 8'hA1;
    localparam logic [7:0] RESET_CMD      = 8'hC1;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    serial_to_onewire_bridge_protocol_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Stimulus and owed responses
    in_t   host_stream[$];
    out_t  host_responses[$];
    out_t  run_bytes[$];
    int    total_items;

    // Shadow protocol state
    mode_t      mode_m;
    logic [7:0] chk_m;
    logic       search_on;
    int         search_cnt;
    logic [7:0] sbuf [16];
    logic [2:0] params [7];

    // Run bookkeeping
    bit   in_fire;
    bit   out_fire;
    int   items_in;
    int   checked;
    int   searches_run;
    int   fails;
    int   stall_cycles;
    out_t want;
    logic quiet;

    assign quiet = (items_in >= QUIET_FIRST) && (items_in < QUIET_LAST);

    function automatic void add_resp(logic [7:0] r, logic [2:0] op, logic [7:0] wr);
        out_t o;
        o.response_byte  = r;
        o.last_of_run    = 1'b0;
        o.bus_op         = op;
        o.bus_write_byte = wr;
        run_bytes.push_back(o);
    endfunction

    // Command-mode decode
    task automatic command_byte(input in_t t);
        logic [7:0] b;
        logic [1:0] code;
        logic [2:0] wsel;
        logic [2:0] v;
        b = t.host_byte;
        if (b == CMD_DATA_MODE) begin
            mode_m = MODE_TOUCH;
        end else if (b == CMD_IGNORE || b == CHECK_BYTE) begin
            // no-op
        end else if ((b & FUNC_MASK) == FUNC_COMMAND) begin
            case (b[6:5])
                FN_BIT: begin
                    add_resp(RESP_BIT | (b & 8'h1C) | (t.bus_read_bit ? 8'h03 : 8'h00),
                             OP_BIT, {7'd0, b[4]});
                    if (b[1])
                        add_resp(t.bus_read_bit ? RESP_BIT_1 : RESP_BIT_0, OP_NONE, 8'h00);
                end
                FN_SEARCH: begin
                    search_on  = b[4];
                    search_cnt = 0;
                end
                FN_RESET: begin
                    if (t.bus_reset_status == RST_PRESENCE)
                        code = RST_PRESENCE;
                    else if (t.bus_reset_status == RST_SHORT)
                        code = RST_SHORT;
                    else
                        code = RST_CODE_NONE;
                    add_resp(RESP_RESET | {6'd0, code}, OP_RESET, 8'h00);
                end
                default: begin
                    add_resp(RESP_PULSE | (b & 8'h12), OP_NONE, 8'h00);
                end
            endcase
        end else if ((b & FUNC_MASK) == FUNC_CONFIG) begin
            wsel = b[6:4];
            if (wsel != 3'd0) begin
                params[wsel - 3'd1] = b[3:1];
                add_resp({1'b0, wsel, b[3:1], 1'b0}, OP_NONE, 8'h00);
            end else begin
                v = (b[3:1] != 3'd0) ? params[b[3:1] - 3'd1] : 3'd0;
                add_resp({4'd0, v, 1'b0}, OP_NONE, 8'h00);
            end
        end
    endtask

    // Resolve 64 search positions into 16 interleaved discrepancy/path bytes
    task automatic run_search(input in_t t);
        int         i;
        logic       idb;
        logic       cb;
        logic       path;
        logic       disc;
        logic [7:0] res [16];
        for (i = 0; i < SEARCH_BYTES; i++)
            res[i] = 8'h00;
        for (i = 0; i < 64; i++) begin
            idb = t.search_id_bits[i];
            cb  = t.search_cmp_bits[i];
            if (idb && cb) begin
                path = 1'b1;
                disc = 1'b0;
            end else if (idb != cb) begin
                path = idb;
                disc = 1'b0;
            end else begin
                path = sbuf[i / 4][(2 * i + 1) % 8];
                disc = 1'b1;
            end
            res[i / 4][(2 * i) % 8]     = disc;
            res[i / 4][(2 * i + 1) % 8] = path;
        end
        for (i = 0; i < SEARCH_BYTES; i++)
            add_resp(res[i], (i == 0) ? OP_SEARCH : OP_NONE, 8'h00);
        searches_run++;
    endtask

    // Data-mode decode
    task automatic data_byte(input in_t t);
        logic [7:0] b;
        b = t.host_byte;
        if (b == CHECK_BYTE) begin
            chk_m  = b;
            mode_m = MODE_CHECK;
        end else if (search_on) begin
            sbuf[search_cnt[3:0]] = b;
            search_cnt++;
            if (search_cnt == SEARCH_BYTES) begin
                search_cnt = 0;
                run_search(t);
            end
        end else begin
            add_resp(t.bus_read_byte, OP_BYTE, b);
        end
    endtask

    // Expected responses for one accepted host byte
    task automatic decode_host_byte(input in_t t);
        out_t o;
        run_bytes.delete();
        case (mode_m)
            MODE_TOUCH: data_byte(t);
            MODE_CHECK: begin
                if (t.host_byte == chk_m) begin
                    add_resp(t.bus_read_byte, OP_BYTE, t.host_byte);
                    mode_m = MODE_TOUCH;
                end else begin
                    command_byte(t);
                    mode_m = MODE_CMD;
                end
            end
            default: command_byte(t);
        endcase
        if (run_bytes.size() != 0)
            run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
        while (run_bytes.size() != 0) begin
            o = run_bytes.pop_front();
            host_responses.push_back(o);
        end
    endtask

    // One host byte with random bus answers
    function automatic in_t host_item(logic [7:0] b);
        in_t t;
        t.host_byte        = b;
        t.bus_read_byte    = 8'($urandom);
        t.bus_read_bit     = 1'($urandom);
        t.bus_reset_status = 2'($urandom_range(0, 3));
        t.chunk_end        = 1'($urandom);
        t.search_id_bits   = {$urandom, $urandom};
        t.search_cmp_bits  = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                t.search_id_bits  = '0;
                t.search_cmp_bits = '0;
            end
            1: begin
                t.search_id_bits  = '1;
                t.search_cmp_bits = '1;
            end
            2: t.search_cmp_bits = ~t.search_id_bits;
            default: ;
        endcase
        return t;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        host_stream.push_back(host_item(b));
    endtask

    // Random data byte that stays clear of the check escape
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CHECK_BYTE)
            b = ~b;
        return b;
    endfunction

    // Random command byte other than the check escape
    function automatic logic [7:0] exit_command();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 1)) begin
            b[7] = 1'b1;
            b[0] = 1'b1;
        end
        if (b == CHECK_BYTE)
            b = RESET_CMD;
        return b;
    endfunction

    // Input driver: new item only once the previous one was transferred
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_fire)) begin
            if (host_stream.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_data  <= host_stream.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Monitor: predict on input transfers, check output transfers, watchdog
    always @(posedge aclk) begin
        in_fire  = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            decode_host_byte(s_data);
            items_in++;
        end
        if (out_fire) begin
            if (host_responses.size() == 0) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("unexpected response: resp %h last %b op %0d wr %h",
                             m_data.response_byte, m_data.last_of_run,
                             m_data.bus_op, m_data.bus_write_byte);
            end else begin
                want = host_responses.pop_front();
                if (m_data !== want) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("response %0d: want %h/%b/%0d/%h got %h/%b/%0d/%h",
                                 checked, want.response_byte, want.last_of_run,
                                 want.bus_op, want.bus_write_byte,
                                 m_data.response_byte, m_data.last_of_run,
                                 m_data.bus_op, m_data.bus_write_byte);
                end
            end
            checked++;
        end
        if (in_fire || out_fire || !aresetn)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, host_responses.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int         kind;
        int         n;
        int         j;
        logic [7:0] b;
        in_t        t;

        mode_m     = MODE_CMD;
        chk_m      = CHECK_BYTE;
        search_on  = 1'b0;
        search_cnt = 0;
        for (j = 0; j < 7; j++)
            params[j] = 3'd0;
        for (j = 0; j < SEARCH_BYTES; j++)
            sbuf[j] = 8'h00;

        // Directed: ignored bytes in command mode
        queue_byte(8'h00);
        queue_byte(8'h80);
        queue_byte(CMD_IGNORE);
        queue_byte(CHECK_BYTE);
        // Single bit: write 0, write 1 with strong-pullup byte for both reads, speed bits
        queue_byte(8'h81);
        t = host_item(8'h93); t.bus_read_bit = 1'b0; host_stream.push_back(t);
        t = host_item(8'h93); t.bus_read_bit = 1'b1; host_stream.push_back(t);
        queue_byte(8'h8F);
        // Reset with short, presence, no presence and the unused status
        for (j = 0; j < 4; j++) begin
            t = host_item(RESET_CMD);
            t.bus_reset_status = j[1:0];
            host_stream.push_back(t);
        end
        // Pulse
        queue_byte(8'hF3);
        // Config writes at the extremes, then reads including code zero
        queue_byte(8'h7F);
        queue_byte(8'h11);
        queue_byte(8'h0F);
        queue_byte(8'h03);
        queue_byte(8'h01);
        // Data mode touches, check escape, escaped check byte, command from check
        queue_byte(CMD_DATA_MODE);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CHECK_BYTE);
        queue_byte(CHECK_BYTE);
        queue_byte(CHECK_BYTE);
        queue_byte(RESET_CMD);
        // Data-mode command byte seen from check mode still returns to command
        queue_byte(CMD_DATA_MODE);
        queue_byte(CHECK_BYTE);
        queue_byte(CMD_DATA_MODE);

        // Random sessions, mostly well formed
        n = host_stream.size() + RANDOM_ITEMS;
        while (host_stream.size() < n) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: queue_byte(8'($urandom));
                2: begin
                    b = 8'($urandom);
                    b[7] = 1'b0;
                    b[0] = 1'b1;
                    queue_byte(b);
                end
                3, 9: begin
                    b = 8'($urandom);
                    b[7] = 1'b1;
                    b[0] = 1'b1;
                    queue_byte(b);
                end
                4, 5, 6: begin
                    queue_byte(CMD_DATA_MODE);
                    for (j = $urandom_range(1, 8); j > 0; j--) begin
                        queue_byte(plain_byte());
                        if ($urandom_range(0, 5) == 0) begin
                            queue_byte(CHECK_BYTE);
                            queue_byte(CHECK_BYTE);
                        end
                    end
                    queue_byte(CHECK_BYTE);
                    queue_byte(exit_command());
                end
                default: begin
                    b = SEARCH_ON_CMD;
                    b[3:1] = 3'($urandom);
                    queue_byte(b);
                    queue_byte(CMD_DATA_MODE);
                    // occasionally a short, broken run
                    kind = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : SEARCH_BYTES;
                    for (j = 0; j < kind; j++) begin
                        queue_byte(plain_byte());
                        if ($urandom_range(0, 15) == 0) begin
                            queue_byte(CHECK_BYTE);
                            queue_byte(CHECK_BYTE);
                        end
                    end
                    queue_byte(CHECK_BYTE);
                    if ($urandom_range(0, 1)) begin
                        b = SEARCH_OFF_CMD;
                        b[3:1] = 3'($urandom);
                        queue_byte(b);
                    end else begin
                        queue_byte(exit_command());
                    end
                end
            endcase
        end
        total_items = host_stream.size();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_in < total_items || host_responses.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d host bytes, %0d responses, %0d search runs, %0d mismatches",
                 items_in, checked, searches_run, fails);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
